// ===== sv/dtp_pkg.sv =====
// Package for the duration text parser: widths, character codes and
// unit-to-seconds constants. No dependencies.
`default_nettype none

package dtp_pkg;

  // Width of the decimal number and of each stored unit count
  localparam int NUMBER_BITS = 20;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;

  // Seconds per unit; the largest (one week) fits in SEC_W bits
  localparam int SEC_W = 20;
  localparam logic [SEC_W-1:0] WEEK_SEC = SEC_W'(7 * 24 * 3600);
  localparam logic [SEC_W-1:0] DAY_SEC  = SEC_W'(24 * 3600);
  localparam logic [SEC_W-1:0] HOUR_SEC = SEC_W'(3600);
  localparam logic [SEC_W-1:0] MIN_SEC  = SEC_W'(60);

  // Product, sum and result widths
  localparam int PROD_W = NUMBER_BITS + SEC_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int MAG_W  = 40;
  localparam int EXT_W  = (SUM_W > MAG_W) ? SUM_W : MAG_W;
  localparam int TOTAL_W = MAG_W + 1;
  localparam int OUT_DATA_W = ((TOTAL_W + 7) / 8) * 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

endpackage : dtp_pkg

`default_nettype wire

// ===== sv/duration_text_parser_top.sv =====
// Duration text parser: turns a duration string into a signed second count.
// A result passes the input register, product register and result register onto out_tdata.
// Throughput: one item per cycle; input register, parse stage, product
// register and result register move together and stall only while a result
// waits on out_tready. Reset (rst_n low, synchronous) empties the pipeline and
// clears all parse state. Depends on dtp_pkg.
`default_nettype none

module duration_text_parser_top
  import dtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  input  wire logic                  in_tlast,   // is_last
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [40:0] total_seconds, rest zero
);

  // pipeline advance: stall only when a result is held and not taken
  logic out_valid_r;
  logic adv;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // input register
  logic              v0_r;
  logic [CHAR_W-1:0] ch0_r;
  logic              last0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
    if (adv) begin
      ch0_r   <= in_tdata;
      last0_r <= in_tlast;
    end
  end

  // parse state
  logic                   neg_r, in_num_r, capt_r;
  logic [NUMBER_BITS-1:0] num_r, wk_r, dy_r, hr_r, mn_r, sc_r;
  logic                   neg_nxt, in_num_nxt, capt_nxt;
  logic [NUMBER_BITS-1:0] num_nxt, wk_nxt, dy_nxt, hr_nxt, mn_nxt, sc_nxt;

  logic [DIGIT_W-1:0]       digit;
  logic                     ch_is_num;
  logic [NUMBER_BITS+3:0]   ext_num;
  logic [NUMBER_BITS+3:0]   num_max_ext;

  assign digit       = DIGIT_W'(ch0_r - CH_ZERO);
  assign ch_is_num   = (ch0_r >= CH_ZERO) && (ch0_r <= CH_NINE);
  assign ext_num     = (NUMBER_BITS + 4)'(num_r) * (NUMBER_BITS + 4)'(10)
                       + (NUMBER_BITS + 4)'(digit);
  assign num_max_ext = (NUMBER_BITS + 4)'({NUMBER_BITS{1'b1}});

  // next state for one character
  always_comb begin
    neg_nxt    = neg_r;
    in_num_nxt = in_num_r;
    capt_nxt   = capt_r;
    num_nxt    = num_r;
    wk_nxt     = wk_r;
    dy_nxt     = dy_r;
    hr_nxt     = hr_r;
    mn_nxt     = mn_r;
    sc_nxt     = sc_r;
    case (ch0_r)
      CH_MINUS: begin
        neg_nxt    = 1'b1;
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
      end
      CH_P, CH_T: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
      end
      CH_W: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
        wk_nxt     = num_r;
      end
      CH_D: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
        dy_nxt     = num_r;
      end
      CH_H: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
        hr_nxt     = num_r;
      end
      CH_M: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
        mn_nxt     = num_r;
      end
      CH_S: begin
        in_num_nxt = 1'b0;
        capt_nxt   = 1'b0;
        sc_nxt     = num_r;
      end
      default: begin
        if (ch_is_num) begin
          if (!in_num_r) begin
            // first digit starts a new number
            num_nxt    = NUMBER_BITS'(digit);
            in_num_nxt = 1'b1;
            capt_nxt   = 1'b1;
          end else if (capt_r) begin
            // extend, saturating at the all-ones value
            num_nxt = (ext_num > num_max_ext) ? {NUMBER_BITS{1'b1}}
                                              : ext_num[NUMBER_BITS-1:0];
          end
        end else begin
          // junk character: rest of this digit run is ignored
          capt_nxt = 1'b0;
        end
      end
    endcase
  end

  // state update; a last character clears everything after it is used
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && v0_r && last0_r)) begin
      neg_r    <= 1'b0;
      in_num_r <= 1'b0;
      capt_r   <= 1'b0;
      num_r    <= '0;
      wk_r     <= '0;
      dy_r     <= '0;
      hr_r     <= '0;
      mn_r     <= '0;
      sc_r     <= '0;
    end else if (adv && v0_r) begin
      neg_r    <= neg_nxt;
      in_num_r <= in_num_nxt;
      capt_r   <= capt_nxt;
      num_r    <= num_nxt;
      wk_r     <= wk_nxt;
      dy_r     <= dy_nxt;
      hr_r     <= hr_nxt;
      mn_r     <= mn_nxt;
      sc_r     <= sc_nxt;
    end
  end

  // product register: a constant multiply per unit (seconds pass through), valid on the last character
  logic              v1_r;
  logic              neg1_r;
  logic [PROD_W-1:0] pw_r, pd_r, ph_r, pm_r, ps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r && last0_r;
    end
    if (adv) begin
      neg1_r <= neg_nxt;
      pw_r   <= PROD_W'(wk_nxt) * PROD_W'(WEEK_SEC);
      pd_r   <= PROD_W'(dy_nxt) * PROD_W'(DAY_SEC);
      ph_r   <= PROD_W'(hr_nxt) * PROD_W'(HOUR_SEC);
      pm_r   <= PROD_W'(mn_nxt) * PROD_W'(MIN_SEC);
      ps_r   <= PROD_W'(sc_nxt);
    end
  end

  // sum, saturate to the magnitude range, apply sign
  logic [SUM_W-1:0]   sum;
  logic [EXT_W-1:0]   sum_ext;
  logic [MAG_W-1:0]   mag;
  logic [TOTAL_W-1:0] total;

  assign sum     = SUM_W'(pw_r) + SUM_W'(pd_r) + SUM_W'(ph_r)
                   + SUM_W'(pm_r) + SUM_W'(ps_r);
  assign sum_ext = EXT_W'(sum);
  assign mag     = (sum_ext > EXT_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}}
                                                     : sum_ext[MAG_W-1:0];
  assign total   = neg1_r ? (TOTAL_W'(0) - {1'b0, mag}) : {1'b0, mag};

  // result register
  logic [TOTAL_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v1_r;
    end
    if (adv && v1_r) begin
      total_r <= total;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(total_r);

endmodule : duration_text_parser_top

`default_nettype wire
